FILE: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, constants and tables of the LSB-first bit packer.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int MAX_FIELD_BITS = 23;
  localparam int MAX_ITEM_BITS  = 504;

  localparam int FIELD_W = MAX_FIELD_BITS;      // widest word written
  localparam int ACC_W   = MAX_FIELD_BITS + 7;  // pending bits plus one word
  localparam int CNT_W   = $clog2(ACC_W + 1);
  localparam int NB_W    = 5;                   // bit_count width
  localparam int QUOTA_W = 8;
  localparam int PROD_W  = FIELD_W + QUOTA_W;

  typedef enum logic [1:0] {
    OP_UNSIGNED = 2'd0,
    OP_SIGNED   = 2'd1,
    OP_FLUSH    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  // Most N-bit words an item may hold: MAX_ITEM_BITS / N, N = 2..23, else 0.
  localparam logic [QUOTA_W-1:0] WORD_QUOTA [0:31] = '{
    8'd0,   8'd0,   8'd252, 8'd168, 8'd126, 8'd100, 8'd84,  8'd72,
    8'd63,  8'd56,  8'd50,  8'd45,  8'd42,  8'd38,  8'd36,  8'd33,
    8'd31,  8'd29,  8'd28,  8'd26,  8'd25,  8'd24,  8'd22,  8'd21,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
  };

  // Controller to datapath
  typedef struct packed {
    logic capture;     // take the accepted input item
    logic load_word;   // build the next word and append it to the accumulator
    logic emit_byte;   // move the lowest complete byte to the output register
    logic emit_flush;  // emit the padded partial byte and end the stream
    logic emit_error;  // emit the error result
  } lbp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic bad;         // unused op or width out of range
    logic n_zero;
    logic too_long;    // escape words would overrun the item limit
    logic cnt_ge8;     // a complete byte is in the accumulator
    logic more;        // another word of this item follows
    logic out_free;    // output register can take a result this cycle
  } lbp_sts_t;

endpackage

FILE: src/lbp_ctrl.sv
// ----------------------------------------------------------------------------
// lbp_ctrl
// Sequencer of the bit packer: decodes an item, runs its words and bytes.
// ----------------------------------------------------------------------------
module lbp_ctrl import lbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  lbp_sts_t sts,
  output lbp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_WORD,
    S_EMIT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad || sts.op == OP_FLUSH) begin
          state_nxt = S_RESP;
        end else if (sts.op == OP_SIGNED) begin
          state_nxt = S_CHECK;
        end else if (sts.n_zero) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_WORD;
        end
      end
      S_CHECK: begin
        state_nxt = sts.too_long ? S_RESP : S_WORD;
      end
      S_WORD: begin
        cmd.load_word = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        // drain complete bytes, then fetch the next word or finish
        if (sts.cnt_ge8) begin
          cmd.emit_byte = sts.out_free;
        end else if (sts.more) begin
          state_nxt = S_WORD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          // a flush ends the stream whatever its width field holds
          if (sts.op == OP_FLUSH) begin
            cmd.emit_flush = 1'b1;
          end else begin
            cmd.emit_error = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: src/lbp_dp.sv
// ----------------------------------------------------------------------------
// lbp_dp
// Datapath of the bit packer: item registers, escape reduction, bit
// accumulator and output register.
// ----------------------------------------------------------------------------
module lbp_dp import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  lbp_cmd_t    cmd,
  output lbp_sts_t    sts,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  op_t                op_r;
  logic [NB_W-1:0]    n_r;
  logic [FIELD_W-1:0] val_r;
  logic               neg_r;
  logic [31:0]        mag_r, mag_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               more_r, more_nxt;
  logic               out_valid_r;
  logic [7:0]         out_data_r;
  logic [2:0]         out_user_r;
  logic               out_last_r;

  logic [FIELD_W-1:0] top, lim, mask, word;
  logic [31:0]        in_value;
  logic               last_byte;
  logic [6:0]         need, n_x1, n_x2, n_x3;
  logic               byte_ahead;

  assign in_value = in_tdata[31:0];

  assign top  = FIELD_W'(1) << (n_r - NB_W'(1));
  assign lim  = top - FIELD_W'(1);
  assign mask = FIELD_W'(((FIELD_W + 1)'(1) << n_r) - (FIELD_W + 1)'(1));

  // Signed: escapes while above lim, then the last word; else masked value
  always_comb begin
    word     = '0;
    mag_nxt  = mag_r;
    more_nxt = 1'b0;
    if (op_r == OP_SIGNED) begin
      if (mag_r > 32'(lim)) begin
        word     = top;
        mag_nxt  = mag_r - 32'(lim);
        more_nxt = 1'b1;
      end else if (neg_r) begin
        word = ((top - mag_r[FIELD_W-1:0]) | top) & mask;
      end else begin
        word = mag_r[FIELD_W-1:0];
      end
    end else begin
      word = val_r & mask;
    end
  end

  // Another byte of this item follows when the bits left after this one and
  // the words still to come reach a full byte; a remaining magnitude above
  // j limits means at least j+1 words to come.
  assign need = 7'd16 - 7'(cnt_r);
  assign n_x1 = 7'(n_r);
  assign n_x2 = n_x1 << 1;
  assign n_x3 = n_x2 + n_x1;
  assign byte_ahead = (cnt_r >= CNT_W'(16)) ||
                      (more_r && ((n_x1 >= need) ||
                                  ((n_x2 >= need) && (mag_r > 32'(lim))) ||
                                  ((n_x3 >= need) && (mag_r > (32'(lim) << 1))) ||
                                  (mag_r > ((32'(lim) << 1) + 32'(lim)))));
  assign last_byte = !byte_ahead;

  assign sts.op       = op_r;
  assign sts.bad      = (op_r == OP_UNUSED) || (n_r > NB_W'(MAX_FIELD_BITS)) ||
                        ((op_r == OP_SIGNED) && (n_r < NB_W'(2)));
  assign sts.n_zero   = (n_r == '0);
  assign sts.too_long = mag_r > 32'(prod_r);
  assign sts.cnt_ge8  = (cnt_r >= CNT_W'(8));
  assign sts.more     = more_r;
  assign sts.out_free = !out_valid_r || out_tready;

  // Item registers and product
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(lim) * PROD_W'(WORD_QUOTA[n_r]);
    if (cmd.capture) begin
      op_r  <= op_t'(in_tuser);
      n_r   <= in_tdata[36:32];
      val_r <= in_value[FIELD_W-1:0];
      neg_r <= in_value[31];
      mag_r <= in_value[31] ? (~in_value + 32'd1) : in_value;
    end else if (cmd.load_word) begin
      mag_r <= mag_nxt;
    end
  end

  // Accumulator and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      more_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_word) begin
        acc_r  <= acc_r | (ACC_W'(word) << cnt_r[2:0]);
        cnt_r  <= cnt_r + CNT_W'(n_r);
        more_r <= more_nxt;
      end
      if (cmd.emit_byte) begin
        acc_r       <= acc_r >> 8;
        cnt_r       <= cnt_r - CNT_W'(8);
        out_valid_r <= 1'b1;
      end else if (cmd.emit_flush) begin
        acc_r       <= '0;
        cnt_r       <= '0;
        out_valid_r <= 1'b1;
      end else if (cmd.emit_error) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the result
  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_data_r <= acc_r[7:0];
      out_user_r <= 3'b001;
      out_last_r <= last_byte;
    end else if (cmd.emit_flush) begin
      out_data_r <= acc_r[7:0];
      out_user_r <= {1'b0, 1'b1, (cnt_r != '0)};
      out_last_r <= 1'b1;
    end else if (cmd.emit_error) begin
      out_data_r <= 8'd0;
      out_user_r <= 3'b100;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: src/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-width fields LSB first into a byte stream.
// ----------------------------------------------------------------------------
// One item is taken at a time. A flush, or an item rejected on its op or
// width, runs accept, decode and response; a signed item rejected as too
// long also runs the length check. An unsigned field runs accept, decode, a
// load and a drain step, plus a drain step per completed byte; one of zero
// width ends after decode. A signed field adds the length check and, for
// every escape word, a load step, a drain step and a drain step per byte it
// completes; the count of escape words, which the single subtractor walks
// through one word per load, sets how long large magnitudes take. Bytes leave
// through one output register, one byte a cycle, and a stalled output holds
// the sequencer. The partial byte survives between items until a flush.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [36:32] bit_count, [39:37] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [2:0]  out_tuser,  // [0] byte_valid, [1] end_of_stream, [2] error
  output logic        out_tlast   // last
);

  lbp_cmd_t cmd;
  lbp_sts_t sts;

  lbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
